// ===== rtl/pmsd_pkg.sv =====
// Shared constants and types of the partition maximum-sum engine.
`timescale 1ns / 1ps
package pmsd_pkg;

	// Field widths
	localparam int VAL_W    = 16;
	localparam int SUM_W    = 27;
	localparam int OUT_W    = 26;
	localparam int CFG_W    = 5;
	localparam int SEEN_W   = 11;
	localparam int SEEN_MAX = 2047;

	// Parameter defaults
	localparam int WINDOW_MAX_DEF = 16;
	localparam int ARRAY_MAX_DEF  = 1024;

	// Output field limits
	localparam longint FIELD_HI = 64'sd33554431;
	localparam longint FIELD_LO = -64'sd33554432;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HOLD
	} state_t;

	// Scan token handed from cell to cell
	typedef struct packed {
		logic                    vld;
		logic signed [VAL_W-1:0] run_max;
		logic signed [SUM_W-1:0] best;
	} tok_t;

	// Chain control broadcast by the sequencer
	typedef struct packed {
		logic shift_val;
		logic commit_sum;
		logic clear_sum;
	} ctl_t;

endpackage

// ===== rtl/pmsd_cell.sv =====
// One cell of the look-back chain: one stored element, one stored best sum.
`timescale 1ns / 1ps
module pmsd_cell #(
	parameter int IDX    = 0,
	parameter int SPAN_W = 5
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pmsd_pkg::ctl_t                        ctl,
	input  logic [SPAN_W-1:0]                     span,
	input  logic signed [pmsd_pkg::VAL_W-1:0]     val_in,
	input  logic signed [pmsd_pkg::SUM_W-1:0]     sum_in,
	input  pmsd_pkg::tok_t                        tok_in,
	output logic signed [pmsd_pkg::VAL_W-1:0]     val_out,
	output logic signed [pmsd_pkg::SUM_W-1:0]     sum_out,
	output pmsd_pkg::tok_t                        tok_out
);

	localparam int VW = pmsd_pkg::VAL_W;
	localparam int SW = pmsd_pkg::SUM_W;

	logic signed [VW-1:0] val_q;
	logic signed [SW-1:0] sum_q;
	pmsd_pkg::tok_t       tok_q;

	logic                 active_c;
	logic signed [VW-1:0] run_max_c;
	logic signed [SW-1:0] max_ext_c;
	logic signed [SW-1:0] cand_c;
	pmsd_pkg::tok_t       tok_d;

	// Element history shifts on each accepted item
	always_ff @(posedge clk) begin
		if (ctl.shift_val) begin
			val_q <= val_in;
		end
	end

	// Best-sum history shifts when a result is committed, clears at array end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.clear_sum) begin
			sum_q <= '0;
		end else if (ctl.commit_sum) begin
			sum_q <= sum_in;
		end
	end

	// Candidate for a last part of length IDX+1
	always_comb begin
		active_c  = tok_in.vld && (SPAN_W'(IDX) < span);
		run_max_c = (val_q > tok_in.run_max) ? val_q : tok_in.run_max;
		max_ext_c = {{(SW-VW){run_max_c[VW-1]}}, run_max_c};
		cand_c    = sum_q + max_ext_c * $signed(SW'(IDX + 1));
		tok_d     = tok_in;
		if (active_c) begin
			tok_d.run_max = run_max_c;
			if (IDX == 0 || cand_c > tok_in.best) begin
				tok_d.best = cand_c;
			end
		end
	end

	// Token register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign val_out = val_q;
	assign sum_out = sum_q;
	assign tok_out = tok_q;

endmodule

// ===== rtl/partition_max_sum_dp_unit.sv =====
// Top level: sequencer, configuration register and output stage of the engine.
//
// Usage: signed elements enter on the s_ channel (s_tdata = element, s_tlast ends
// an array). For each element one result leaves on the m_ channel: m_tdata holds
// the best partition sum of the prefix so far, m_tlast marks the answer for the
// whole array. After an s_tlast item the history is cleared for the next array.
// max_part_len is written on the cfg_ channel (cfg_ready is always high) while
// the block is idle; values 0 and above WINDOW_MAX act as 1 and WINDOW_MAX.
// Each element is shifted into the chain, then the scan token walks the row
// of cells and the clamped sum is committed. One element is in work at a time.
// The result sits in a separate output register, so a stalled receiver does not
// stop the scan of the next element; a second finished result waits in a
// holding register and s_tready stays low until the output frees up.
// Reset (arst_n low) clears the stored sums, the item count and all valid
// flags, and sets max_part_len to 1. No clearing pass is needed.
`timescale 1ns / 1ps
module partition_max_sum_dp_unit #(
	parameter int WINDOW_MAX = pmsd_pkg::WINDOW_MAX_DEF,
	parameter int ARRAY_MAX  = pmsd_pkg::ARRAY_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write: max_part_len
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	// Input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] element_value
	input  logic        s_tlast,   // last_item
	// Result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [25:0] best_sum, [31:26] zero
	output logic        m_tlast    // final_result
);

	localparam int VW     = pmsd_pkg::VAL_W;
	localparam int SW     = pmsd_pkg::SUM_W;
	localparam int OW     = pmsd_pkg::OUT_W;
	localparam int NW     = pmsd_pkg::SEEN_W;
	localparam int SPAN_W = $clog2(WINDOW_MAX + 1);

	localparam longint RAW_HI = longint'(ARRAY_MAX) * 32767;
	localparam longint RAW_LO = longint'(ARRAY_MAX) * -32768;
	localparam longint LIM_HI = (RAW_HI < pmsd_pkg::FIELD_HI) ? RAW_HI : pmsd_pkg::FIELD_HI;
	localparam longint LIM_LO = (RAW_LO > pmsd_pkg::FIELD_LO) ? RAW_LO : pmsd_pkg::FIELD_LO;
	localparam logic signed [SW-1:0] SUM_HI = SW'(LIM_HI);
	localparam logic signed [SW-1:0] SUM_LO = SW'(LIM_LO);

	// Control and configuration registers
	pmsd_pkg::state_t               state_q, state_d;
	logic [pmsd_pkg::CFG_W-1:0]     cfg_q;
	logic [NW-1:0]                  seen_q;
	logic [SPAN_W-1:0]              span_q;
	logic                           last_q;
	logic                           launch_q;
	logic                           m_valid_q;
	logic [OW-1:0]                  m_data_q;
	logic                           m_last_q;
	logic [OW-1:0]                  pend_q;

	// Chain wiring
	pmsd_pkg::ctl_t                 ctl;
	logic signed [VW-1:0]           val_w [WINDOW_MAX];
	logic signed [SW-1:0]           sum_w [WINDOW_MAX];
	pmsd_pkg::tok_t                 tok_w [WINDOW_MAX];
	pmsd_pkg::tok_t                 tok_head;

	logic                           accept;
	logic                           exit_c;
	logic                           out_free;
	logic                           load_out;
	logic                           load_pend;
	logic [NW-1:0]                  k_c;
	logic [NW-1:0]                  n_c;
	logic [NW-1:0]                  span_c;
	logic signed [SW-1:0]           best_c;

	assign cfg_ready = 1'b1;
	assign out_free  = !m_valid_q || m_tready;
	assign exit_c    = (state_q == pmsd_pkg::ST_SCAN) && tok_w[WINDOW_MAX-1].vld;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pmsd_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = pmsd_pkg::ST_SCAN;
			end
			pmsd_pkg::ST_SCAN: begin
				if (exit_c) state_d = out_free ? pmsd_pkg::ST_IDLE : pmsd_pkg::ST_HOLD;
			end
			pmsd_pkg::ST_HOLD: begin
				if (out_free) state_d = pmsd_pkg::ST_IDLE;
			end
			default: state_d = pmsd_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_tready       = (state_q == pmsd_pkg::ST_IDLE);
		accept         = s_tready && s_tvalid;
		ctl.shift_val  = accept;
		ctl.commit_sum = exit_c && !last_q;
		ctl.clear_sum  = exit_c && last_q;
		load_out       = exit_c && out_free;
		load_pend      = (state_q == pmsd_pkg::ST_HOLD) && out_free;
	end

	// Effective part length and look-back span
	always_comb begin
		if (cfg_q == '0) begin
			k_c = NW'(1);
		end else if (NW'(cfg_q) > NW'(WINDOW_MAX)) begin
			k_c = NW'(WINDOW_MAX);
		end else begin
			k_c = NW'(cfg_q);
		end
		n_c    = (seen_q < NW'(pmsd_pkg::SEEN_MAX)) ? seen_q + NW'(1) : NW'(pmsd_pkg::SEEN_MAX);
		span_c = (n_c < k_c) ? n_c : k_c;
	end

	// Clamp of the scan result
	always_comb begin
		best_c = tok_w[WINDOW_MAX-1].best;
		if (best_c > SUM_HI) begin
			best_c = SUM_HI;
		end else if (best_c < SUM_LO) begin
			best_c = SUM_LO;
		end
	end

	// Token entering the first cell
	always_comb begin
		tok_head.vld     = launch_q;
		tok_head.run_max = {1'b1, {(VW-1){1'b0}}};
		tok_head.best    = '0;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pmsd_pkg::ST_IDLE;
			cfg_q     <= pmsd_pkg::CFG_W'(1);
			seen_q    <= '0;
			launch_q  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= accept;
			if (cfg_valid) begin
				cfg_q <= cfg_data;
			end
			if (accept) begin
				seen_q <= n_c;
			end else if (exit_c && last_q) begin
				seen_q <= '0;
			end
			if (load_out || load_pend) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Item registers
	always_ff @(posedge clk) begin
		if (accept) begin
			span_q <= SPAN_W'(span_c);
			last_q <= s_tlast;
		end
		if (exit_c) begin
			pend_q <= OW'(best_c);
		end
		if (load_out) begin
			m_data_q <= OW'(best_c);
			m_last_q <= last_q;
		end else if (load_pend) begin
			m_data_q <= pend_q;
			m_last_q <= last_q;
		end
	end

	// Row of cells
	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		if (i == 0) begin : g_head
			pmsd_cell #(.IDX(i), .SPAN_W(SPAN_W)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.span    (span_q),
				.val_in  (s_tdata),
				.sum_in  (best_c),
				.tok_in  (tok_head),
				.val_out (val_w[i]),
				.sum_out (sum_w[i]),
				.tok_out (tok_w[i])
			);
		end else begin : g_body
			pmsd_cell #(.IDX(i), .SPAN_W(SPAN_W)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.span    (span_q),
				.val_in  (val_w[i-1]),
				.sum_in  (sum_w[i-1]),
				.tok_in  (tok_w[i-1]),
				.val_out (val_w[i]),
				.sum_out (sum_w[i]),
				.tok_out (tok_w[i])
			);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(32-OW){1'b0}}, m_data_q};
	assign m_tlast  = m_last_q;

endmodule
